// ----- src/rqsm_pkg.sv -----
// ----------------------------------------------------------------------------
// rqsm_pkg
// Shared types and codes for the ring queue slot manager: command and status
// codes, register indexes, request/result payloads and the multiply-add
// unit's control and status bundles.
// ----------------------------------------------------------------------------
package rqsm_pkg;

    localparam int ADDR_W      = 48;
    localparam int LEN_W       = 16;
    localparam int COUNT_W     = 32;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 48;
    localparam int CFG_INDEX_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ENQUEUE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ALLOCATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOT_SIZE      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_QUEUE_CAPACITY = 2'd2;

    // Reset values of the configuration registers
    localparam logic [ADDR_W-1:0] BASE_ADDRESS_RESET   = '0;
    localparam logic [LEN_W-1:0]  SLOT_SIZE_RESET      = 16'd64;
    localparam logic [LEN_W-1:0]  QUEUE_CAPACITY_RESET = 16'd16;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [LEN_W-1:0] request_length;
    } rqsm_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   slot_address;
        logic [LEN_W-1:0]    transfer_length;
        logic [COUNT_W-1:0]  enqueue_total;
        logic [COUNT_W-1:0]  dequeue_total;
    } rqsm_rsp_t;

    // Multiply-add unit: sum = addend + multiplicand * multiplier
    typedef struct packed {
        logic              load;
        logic [ADDR_W-1:0] addend;
        logic [ADDR_W-1:0] multiplicand;
        logic [LEN_W-1:0]  multiplier;
    } rqsm_mac_ctrl_t;

    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] sum;
    } rqsm_mac_stat_t;

endpackage

// ----- src/rqsm_mac.sv -----
// ----------------------------------------------------------------------------
// rqsm_mac
// Shift-and-add multiply-accumulate unit. One adder steps through the
// multiplier one bit per cycle and stops as soon as no set bits remain.
// ----------------------------------------------------------------------------
module rqsm_mac
    import rqsm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  rqsm_mac_ctrl_t ctrl,
    output rqsm_mac_stat_t stat
);

    logic [ADDR_W-1:0] acc_reg;
    logic [ADDR_W-1:0] mcand_reg;
    logic [LEN_W-1:0]  mplier_reg;
    logic              run_reg;
    logic              done_reg;
    logic [ADDR_W-1:0] acc_next;

    // Add the shifted multiplicand when the current multiplier bit is set
    assign acc_next = acc_reg + (mplier_reg[0] ? mcand_reg : '0);

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.load)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && (mplier_reg == '0))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Advance the datapath one multiplier bit per cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            acc_reg    <= ctrl.addend;
            mcand_reg  <= ctrl.multiplicand;
            mplier_reg <= ctrl.multiplier;
        end
        else if (run_reg && (mplier_reg != '0))
        begin
            acc_reg    <= acc_next;
            mcand_reg  <= {mcand_reg[ADDR_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[LEN_W-1:1]};
        end
    end

    assign stat.done = done_reg;
    assign stat.sum  = acc_reg;

endmodule

// ----- src/ring_queue_slot_manager_top.sv -----
// ----------------------------------------------------------------------------
// ring_queue_slot_manager_top
// Descriptor engine for a shared-memory ring queue: checks each command,
// moves head or tail and returns status, slot address and running totals.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with a request (command, request_length) while busy is low;
//   the request is taken at that clock edge. Exactly one result follows on
//   the result port, marked by a one-cycle result_valid strobe.
//   A request that fails its length, full or empty check returns its result
//   in the cycle after acceptance. A successful request computes the slot
//   address base + (index + 1) * slot_size on a shift-and-add unit that
//   retires one bit of slot_size per cycle. busy stays high until the strobe,
//   so no new request is taken while one is in flight; the next request may
//   be issued in the strobe cycle.
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data),
//   index 0 base address, 1 slot size, 2 queue capacity; write it only while
//   no request is in flight. Index 3 is ignored.
//   Reset clears head, tail and both totals and loads the register defaults
//   (base 0, slot size 64, capacity 16). The receiver cannot stall: each
//   result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module ring_queue_slot_manager_top
    import rqsm_pkg::*;
#(
    parameter int INDEX_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  rqsm_req_t              request,
    output logic                   result_valid,
    output rqsm_rsp_t              result,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int CMP_W = LEN_W + 1;

    typedef enum logic {
        S_IDLE,
        S_MUL
    } state_t;

    state_t               state_reg;
    logic [INDEX_BITS-1:0] head_reg;
    logic [INDEX_BITS-1:0] tail_reg;
    logic [COUNT_W-1:0]   enq_cnt_reg;
    logic [COUNT_W-1:0]   deq_cnt_reg;
    logic [ADDR_W-1:0]    base_reg;
    logic [LEN_W-1:0]     slot_size_reg;
    logic [LEN_W-1:0]     capacity_reg;
    rqsm_rsp_t            rsp_reg;
    logic                 rsp_valid_reg;

    logic                 accept;
    logic [INDEX_BITS-1:0] head_next;
    logic [INDEX_BITS-1:0] tail_next;
    logic [COUNT_W-1:0]   enq_cnt_next;
    logic [COUNT_W-1:0]   deq_cnt_next;
    logic [STATUS_W-1:0]  status_c;
    logic [LEN_W-1:0]     xfer_c;
    logic                 use_head;
    logic                 move_head;
    logic                 move_tail;
    logic [INDEX_BITS-1:0] slot_idx;
    rqsm_mac_ctrl_t       mac_ctrl;
    rqsm_mac_stat_t       mac_stat;

    // Next ring index: wrap to zero at or beyond the capacity
    function automatic logic [INDEX_BITS-1:0] advance(
        input logic [INDEX_BITS-1:0] idx,
        input logic [LEN_W-1:0]      cap
    );
        logic [INDEX_BITS:0] nxt;
        begin
            nxt = {1'b0, idx} + {{INDEX_BITS{1'b0}}, 1'b1};
            if (CMP_W'(nxt) >= CMP_W'(cap))
            begin
                advance = '0;
            end
            else
            begin
                advance = nxt[INDEX_BITS-1:0];
            end
        end
    endfunction

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign head_next = advance(head_reg, capacity_reg);
    assign tail_next = advance(tail_reg, capacity_reg);

    // Decode the command: length check first, then full or empty
    always_comb
    begin
        status_c  = ST_OK;
        xfer_c    = '0;
        use_head  = 1'b0;
        move_head = 1'b0;
        move_tail = 1'b0;
        unique case (request.command) inside
            CMD_ENQUEUE, CMD_ALLOCATE:
            begin
                use_head = 1'b1;
                if ((request.command == CMD_ENQUEUE) &&
                    ((request.request_length == '0) ||
                     (request.request_length > slot_size_reg)))
                begin
                    status_c = ST_BAD_LEN;
                end
                else if (head_next == tail_reg)
                begin
                    status_c = ST_FULL;
                end
                else
                begin
                    move_head = 1'b1;
                    if (request.command == CMD_ENQUEUE)
                    begin
                        xfer_c = request.request_length;
                    end
                end
            end
            CMD_DEQUEUE, CMD_PEEK, CMD_RELEASE:
            begin
                if ((request.command != CMD_RELEASE) && (request.request_length == '0))
                begin
                    status_c = ST_BAD_LEN;
                end
                else if (tail_reg == head_reg)
                begin
                    status_c = ST_EMPTY;
                end
                else
                begin
                    if (request.command != CMD_RELEASE)
                    begin
                        xfer_c = (request.request_length < slot_size_reg) ?
                                 request.request_length : slot_size_reg;
                    end
                    if (request.command != CMD_PEEK)
                    begin
                        move_tail = 1'b1;
                    end
                end
            end
            default:
            begin
                status_c = ST_BAD_LEN;
            end
        endcase
    end

    assign enq_cnt_next = move_head ? (enq_cnt_reg + COUNT_W'(1)) : enq_cnt_reg;
    assign deq_cnt_next = move_tail ? (deq_cnt_reg + COUNT_W'(1)) : deq_cnt_reg;
    assign slot_idx     = use_head ? head_reg : tail_reg;

    // Launch base + (index + 1) * slot_size on a successful request
    assign mac_ctrl.load         = accept && (status_c == ST_OK);
    assign mac_ctrl.addend       = base_reg;
    assign mac_ctrl.multiplicand = ADDR_W'({1'b0, slot_idx} + {{INDEX_BITS{1'b0}}, 1'b1});
    assign mac_ctrl.multiplier   = slot_size_reg;

    rqsm_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .stat  (mac_stat)
    );

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= BASE_ADDRESS_RESET;
            slot_size_reg <= SLOT_SIZE_RESET;
            capacity_reg  <= QUEUE_CAPACITY_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BASE_ADDRESS:   base_reg      <= cfg_data[ADDR_W-1:0];
                REG_SLOT_SIZE:      slot_size_reg <= cfg_data[LEN_W-1:0];
                REG_QUEUE_CAPACITY: capacity_reg  <= cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // Sequence requests, move pointers and drive the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            enq_cnt_reg   <= '0;
            deq_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (move_head)
                        begin
                            head_reg <= head_next;
                        end
                        if (move_tail)
                        begin
                            tail_reg <= tail_next;
                        end
                        enq_cnt_reg             <= enq_cnt_next;
                        deq_cnt_reg             <= deq_cnt_next;
                        rsp_reg.status          <= status_c;
                        rsp_reg.slot_address    <= '0;
                        rsp_reg.transfer_length <= xfer_c;
                        rsp_reg.enqueue_total   <= enq_cnt_next;
                        rsp_reg.dequeue_total   <= deq_cnt_next;
                        if (status_c == ST_OK)
                        begin
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            rsp_valid_reg <= 1'b1;
                        end
                    end
                end
                S_MUL:
                begin
                    if (mac_stat.done)
                    begin
                        rsp_reg.slot_address <= mac_stat.sum;
                        rsp_valid_reg        <= 1'b1;
                        state_reg            <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = rsp_valid_reg;
    assign result       = rsp_reg;

endmodule
